// ===== src/f2i8q_pkg.sv =====
// ----------------------------------------------------------------------------
// f2i8q_pkg: shared definitions for the fp32 to int8 quantizer
// Window widths of the fixed-point fused sum, saturation limits, the adder
// enable struct and the side struct that travels along the pipeline.
// ----------------------------------------------------------------------------
package f2i8q_pkg;

	// fixed-point window: position 0 is 2^-53 (sticky), position 181 is 2^128
	localparam int WIN_W  = 182;
	localparam int SUM_W  = 184;
	localparam int LO_W   = 92;
	localparam int HI_W   = SUM_W - LO_W;
	// product field: positions -48 to 229, bias field: positions -24 to 181
	localparam int PFLD_W = 278;
	localparam int BFLD_W = 206;

	localparam logic signed [7:0] Q_MAX = 8'sd127;
	localparam logic signed [7:0] Q_MIN = -8'sd128;

	typedef struct packed {
		logic               lo;
		logic               hi;
	} add_en_t;

	typedef struct packed {
		logic               special;
		logic signed [7:0]  special_q;
		logic               prod_neg;
	} side_t;

endpackage

// ===== src/fp32_to_int8_quantizer.sv =====
// ----------------------------------------------------------------------------
// fp32_to_int8_quantizer: fused sample*scale+bias, round, saturate to int8
// Registers s1 to s6 and out lie from request to result; one request per
// cycle while req_stall is low. A stage holds only while the next one is
// full and held, so bubbles close up; requests stall only when all are full.
// Reset clears the valid bits only; the datapath registers carry no reset.
// ----------------------------------------------------------------------------
module fp32_to_int8_quantizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [31:0]        sample_bits,
	input  logic [31:0]        scale_bits,
	input  logic [31:0]        offset_bits,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [7:0]  quantized
);

	// Stage map:
	//   s1  decode, special cases, 24x24 mantissa product, alignment shifts
	//   s2  place product and bias in the fixed-point window, fold sticky bits
	//   s3  low half of the signed sum
	//   s4  high half of the signed sum
	//   s5  range check against 2^8 and magnitude of the low segment
	//   s6  round the magnitude to single precision (nearest even)
	//   out round to integer (ties away), saturate, apply special result

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_q;
	logic en_1, en_2, en_3, en_4, en_5, en_6, en_o;

	// advance a stage whenever it is empty or the next one advances
	assign en_o = !v_q || !res_stall;
	assign en_6 = !v_s6 || en_o;
	assign en_5 = !v_s5 || en_6;
	assign en_4 = !v_s4 || en_5;
	assign en_3 = !v_s3 || en_4;
	assign en_2 = !v_s2 || en_3;
	assign en_1 = !v_s1 || en_2;
	assign req_stall = !en_1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (en_1) v_s1 <= req_valid;
			if (en_2) v_s2 <= v_s1;
			if (en_3) v_s3 <= v_s2;
			if (en_4) v_s4 <= v_s3;
			if (en_5) v_s5 <= v_s4;
			if (en_6) v_s6 <= v_s5;
			if (en_o) v_q  <= v_s6;
		end
	end

	assign res_valid = v_q;

	// ------------------------------------------------------------------
	// s1: decode operands and sort out the special cases
	// ------------------------------------------------------------------
	logic [30:0] s_abs, k_abs, o_abs;
	logic        s_nan, k_nan, o_nan, s_inf, k_inf, o_inf;
	logic        sp, so;
	logic [7:0]  ee_s, ee_k, ee_o;
	logic [23:0] m_s, m_k, m_o;
	logic [8:0]  e_sum;
	logic [8:0]  sh_p_full;
	logic [7:0]  sh_p, sh_b;
	f2i8q_pkg::side_t side_in;

	assign s_abs = sample_bits[30:0];
	assign k_abs = scale_bits[30:0];
	assign o_abs = offset_bits[30:0];
	assign s_nan = s_abs > 31'h7F80_0000;
	assign k_nan = k_abs > 31'h7F80_0000;
	assign o_nan = o_abs > 31'h7F80_0000;
	assign s_inf = s_abs == 31'h7F80_0000;
	assign k_inf = k_abs == 31'h7F80_0000;
	assign o_inf = o_abs == 31'h7F80_0000;
	assign sp    = sample_bits[31] ^ scale_bits[31];
	assign so    = offset_bits[31];

	// subnormals take the exponent of the smallest normal and no hidden bit
	assign ee_s = (sample_bits[30:23] == 8'd0) ? 8'd1 : sample_bits[30:23];
	assign ee_k = (scale_bits[30:23]  == 8'd0) ? 8'd1 : scale_bits[30:23];
	assign ee_o = (offset_bits[30:23] == 8'd0) ? 8'd1 : offset_bits[30:23];
	assign m_s  = {sample_bits[30:23] != 8'd0, sample_bits[22:0]};
	assign m_k  = {scale_bits[30:23]  != 8'd0, scale_bits[22:0]};
	assign m_o  = {offset_bits[30:23] != 8'd0, offset_bits[22:0]};

	// product LSB sits at field index ee_s + ee_k - 199, clamped to the field
	assign e_sum     = {1'b0, ee_s} + {1'b0, ee_k};
	assign sh_p_full = (e_sum < 9'd199) ? 9'd0 : e_sum - 9'd199;
	assign sh_p      = (sh_p_full > 9'd230) ? 8'd230 : sh_p_full[7:0];
	// bias LSB sits at field index ee_o - 73
	assign sh_b      = (ee_o < 8'd73) ? 8'd0 : ee_o - 8'd73;

	always_comb begin
		side_in.prod_neg  = sp;
		side_in.special   = 1'b1;
		side_in.special_q = f2i8q_pkg::Q_MAX;
		priority if (s_nan || k_nan || o_nan) begin
			side_in.special_q = f2i8q_pkg::Q_MAX;
		end else if (s_inf || k_inf) begin
			// infinity times zero, or opposite infinities: invalid
			if (s_abs == 31'd0 || k_abs == 31'd0 || (o_inf && so != sp)) begin
				side_in.special_q = f2i8q_pkg::Q_MAX;
			end else begin
				side_in.special_q = sp ? f2i8q_pkg::Q_MIN : f2i8q_pkg::Q_MAX;
			end
		end else if (o_inf) begin
			side_in.special_q = so ? f2i8q_pkg::Q_MIN : f2i8q_pkg::Q_MAX;
		end else begin
			side_in.special = 1'b0;
		end
	end

	logic [47:0]        prod_s1;
	logic [23:0]        mo_s1;
	logic [7:0]         shp_s1, shb_s1;
	logic               eff_sub_s1;
	f2i8q_pkg::side_t   side_s1;

	always_ff @(posedge clk) begin
		if (en_1) begin
			prod_s1    <= m_s * m_k;
			mo_s1      <= m_o;
			shp_s1     <= sh_p;
			shb_s1     <= sh_b;
			eff_sub_s1 <= sp ^ so;
			side_s1    <= side_in;
		end
	end

	// ------------------------------------------------------------------
	// s2: align into the window; anything below 2^-52 folds into bit 0
	// ------------------------------------------------------------------
	logic [f2i8q_pkg::PFLD_W-1:0] pfld;
	logic [f2i8q_pkg::BFLD_W-1:0] bfld;
	logic [f2i8q_pkg::WIN_W-1:0]  pop, bop;
	logic                         p_big;

	assign pfld  = {{(f2i8q_pkg::PFLD_W-48){1'b0}}, prod_s1} << shp_s1;
	assign bfld  = {{(f2i8q_pkg::BFLD_W-24){1'b0}}, mo_s1} << shb_s1;
	assign pop   = {pfld[229:49], pfld[48] | (|pfld[47:0])};
	assign bop   = {bfld[205:25], bfld[24] | (|bfld[23:0])};
	// product at or beyond 2^129 dwarfs any bias: saturate by its sign
	assign p_big = |pfld[277:230];

	logic [f2i8q_pkg::WIN_W-1:0]  pop_s2, bop_s2;
	logic                         eff_sub_s2, p_big_s2;
	f2i8q_pkg::side_t             side_s2;

	always_ff @(posedge clk) begin
		if (en_2) begin
			pop_s2     <= pop;
			bop_s2     <= bop;
			eff_sub_s2 <= eff_sub_s1;
			p_big_s2   <= p_big;
			side_s2    <= side_s1;
		end
	end

	// ------------------------------------------------------------------
	// s3/s4: signed sum, product minus bias when the signs differ
	// ------------------------------------------------------------------
	logic [f2i8q_pkg::SUM_W-1:0]  add_a, add_b, sum_s4;
	f2i8q_pkg::add_en_t           add_en;

	assign add_a     = {2'b00, pop_s2};
	assign add_b     = eff_sub_s2 ? ~{2'b00, bop_s2} : {2'b00, bop_s2};
	assign add_en.lo = en_3;
	assign add_en.hi = en_4;

	f2i8q_wide_add u_add (
		.clk (clk),
		.en  (add_en),
		.a   (add_a),
		.b   (add_b),
		.cin (eff_sub_s2),
		.sum (sum_s4)
	);

	logic               p_big_s3, p_big_s4;
	f2i8q_pkg::side_t   side_s3, side_s4;

	always_ff @(posedge clk) begin
		if (en_3) begin
			p_big_s3 <= p_big_s2;
			side_s3  <= side_s2;
		end
		if (en_4) begin
			p_big_s4 <= p_big_s3;
			side_s4  <= side_s3;
		end
	end

	// ------------------------------------------------------------------
	// s5: anything of magnitude 2^8 or more saturates; otherwise take the
	// magnitude of the 61-bit segment from 2^7 down to the sticky bit
	// ------------------------------------------------------------------
	logic        d_neg, in_range, sum_neg;
	logic [60:0] low_seg, mag;

	assign d_neg    = sum_s4[f2i8q_pkg::SUM_W-1];
	assign low_seg  = sum_s4[60:0];
	assign in_range = (sum_s4[f2i8q_pkg::SUM_W-1:61] == {(f2i8q_pkg::SUM_W-61){d_neg}})
		&& !(d_neg && low_seg == 61'd0);
	assign mag      = d_neg ? (61'd0 - low_seg) : low_seg;
	assign sum_neg  = side_s4.prod_neg ^ d_neg;

	logic [60:0]        mag_s5;
	logic               sat_s5, neg_s5;
	f2i8q_pkg::side_t   side_s5;

	always_ff @(posedge clk) begin
		if (en_5) begin
			mag_s5  <= mag;
			sat_s5  <= p_big_s4 || !in_range;
			neg_s5  <= p_big_s4 ? side_s4.prod_neg : sum_neg;
			side_s5 <= side_s4;
		end
	end

	// ------------------------------------------------------------------
	// s6: single-precision rounding; below 2^-2 the result is zero anyway
	// ------------------------------------------------------------------
	logic [3:0]  lead_off;
	logic [5:0]  lsb_pos;
	logic [60:0] low_mask;
	logic        lead_nz, g_bit, s_bit, l_bit;
	logic [61:0] rnd;

	always_comb begin
		lead_off = 4'd0;
		for (int k = 0; k < 10; k++) begin
			if (mag_s5[51 + k]) lead_off = 4'(k);
		end
	end

	assign lead_nz  = |mag_s5[60:51];
	assign lsb_pos  = 6'd28 + {2'b00, lead_off};
	assign low_mask = (61'd1 << lsb_pos) - 61'd1;
	assign l_bit    = mag_s5[lsb_pos];
	assign g_bit    = mag_s5[lsb_pos - 6'd1];
	assign s_bit    = |(mag_s5 & (low_mask >> 1));
	assign rnd      = !lead_nz ? 62'd0 :
		({1'b0, mag_s5 & ~low_mask} + ((g_bit && (s_bit || l_bit)) ? (62'd1 << lsb_pos) : 62'd0));

	logic [61:0]        rnd_s6;
	logic               sat_s6, neg_s6;
	f2i8q_pkg::side_t   side_s6;

	always_ff @(posedge clk) begin
		if (en_6) begin
			rnd_s6  <= rnd;
			sat_s6  <= sat_s5;
			neg_s6  <= neg_s5;
			side_s6 <= side_s5;
		end
	end

	// ------------------------------------------------------------------
	// out: integer rounding with ties away from zero, then saturate
	// ------------------------------------------------------------------
	logic [9:0]        ival;
	logic signed [7:0] q_next;

	assign ival = {1'b0, rnd_s6[61:53]} + {9'd0, rnd_s6[52]};

	always_comb begin
		priority if (side_s6.special) begin
			q_next = side_s6.special_q;
		end else if (sat_s6) begin
			q_next = neg_s6 ? f2i8q_pkg::Q_MIN : f2i8q_pkg::Q_MAX;
		end else if (neg_s6) begin
			q_next = (ival > 10'd128) ? f2i8q_pkg::Q_MIN : 8'(10'd0 - ival);
		end else begin
			q_next = (ival > 10'd127) ? f2i8q_pkg::Q_MAX : ival[7:0];
		end
	end

	logic signed [7:0] quantized_q;

	always_ff @(posedge clk) begin
		if (en_o) begin
			quantized_q <= q_next;
		end
	end

	assign quantized = quantized_q;

endmodule

// ===== src/f2i8q_wide_add.sv =====
// ----------------------------------------------------------------------------
// f2i8q_wide_add: two-stage split adder
// Adds the low half in the first stage, the high half with the carry in the
// second.
// ----------------------------------------------------------------------------
module f2i8q_wide_add (
	input  logic                          clk,
	input  f2i8q_pkg::add_en_t            en,
	input  logic [f2i8q_pkg::SUM_W-1:0]   a,
	input  logic [f2i8q_pkg::SUM_W-1:0]   b,
	input  logic                          cin,
	output logic [f2i8q_pkg::SUM_W-1:0]   sum
);

	logic [f2i8q_pkg::LO_W:0]     lo_full;
	logic [f2i8q_pkg::LO_W-1:0]   lo_s3;
	logic                         c_s3;
	logic [f2i8q_pkg::HI_W-1:0]   ahi_s3;
	logic [f2i8q_pkg::HI_W-1:0]   bhi_s3;
	logic [f2i8q_pkg::SUM_W-1:0]  sum_s4;

	assign lo_full = {1'b0, a[f2i8q_pkg::LO_W-1:0]} + {1'b0, b[f2i8q_pkg::LO_W-1:0]}
		+ {{f2i8q_pkg::LO_W{1'b0}}, cin};

	always_ff @(posedge clk) begin
		if (en.lo) begin
			lo_s3  <= lo_full[f2i8q_pkg::LO_W-1:0];
			c_s3   <= lo_full[f2i8q_pkg::LO_W];
			ahi_s3 <= a[f2i8q_pkg::SUM_W-1:f2i8q_pkg::LO_W];
			bhi_s3 <= b[f2i8q_pkg::SUM_W-1:f2i8q_pkg::LO_W];
		end
		if (en.hi) begin
			sum_s4 <= {ahi_s3 + bhi_s3 + {{(f2i8q_pkg::HI_W-1){1'b0}}, c_s3}, lo_s3};
		end
	end

	assign sum = sum_s4;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for fp32_to_int8_quantizer
// Walks a table of hand-picked requests (signed zeros, ties, saturation,
// infinities, NaN, invalid products, subnormals), then ~800 random requests
// under four flow-control phases. Each request is predicted by a bit-exact
// fused multiply-add and round/saturate model kept in this file, or takes the
// directed row's fixed value; results are checked in order against the oldest.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM   = 800;
	localparam int IDLE_LIMIT = 4000;	// cycles with no request or result accepted
	localparam int DRAIN_WAIT = 20;		// extra wait once nothing is pending, as a margin

	// fp32 patterns used by the directed table
	localparam logic [31:0] F_ZERO   = 32'h0000_0000;
	localparam logic [31:0] F_NZERO  = 32'h8000_0000;
	localparam logic [31:0] F_ONE    = 32'h3F80_0000;
	localparam logic [31:0] F_HALF   = 32'h3F00_0000;
	localparam logic [31:0] F_NHALF  = 32'hBF00_0000;
	localparam logic [31:0] F_PINF   = 32'h7F80_0000;
	localparam logic [31:0] F_NINF   = 32'hFF80_0000;
	localparam logic [31:0] F_QNAN   = 32'h7FC0_0000;
	localparam logic [31:0] F_PMAX   = 32'h7F7F_FFFF;
	localparam logic [31:0] F_NMAX   = 32'hFF7F_FFFF;
	localparam logic [31:0] F_MINSUB = 32'h0000_0001;

	typedef struct {
		logic [31:0]       sample;
		logic [31:0]       scale;
		logic [31:0]       offset;
		logic              use_model;	// expected value comes from the predictor
		logic signed [7:0] q;
	} quant_row_t;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	logic [31:0]       sample_bits;
	logic [31:0]       scale_bits;
	logic [31:0]       offset_bits;
	logic              res_valid;
	logic              res_stall;
	logic signed [7:0] quantized;

	logic signed [7:0] pending_q[$];	// predicted results not yet returned
	int                n_mismatch;
	int                n_checked;
	int                idle_cycles;
	int                sender_idle_pct;
	int                stall_pct;

	fp32_to_int8_quantizer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.sample_bits (sample_bits),
		.scale_bits  (scale_bits),
		.offset_bits (offset_bits),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.quantized   (quantized)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Fused sample*scale+offset, one RNE step to fp32, then round half away
	// from zero and clamp to int8. The exact sum lives in a 576-bit window
	// whose bit 298 has weight 1.0; bit 149 is the fp32 subnormal LSB.
	function automatic logic signed [7:0] predict_quant(input logic [31:0] s,
			input logic [31:0] k, input logic [31:0] o);
		logic [575:0] prod;
		logic [575:0] bias;
		logic [575:0] acc;
		logic [47:0]  pm;
		logic [23:0]  ms;
		logic [23:0]  mk;
		logic [23:0]  mo;
		logic [63:0]  r;
		logic [63:0]  mag;
		int           es;
		int           ek;
		int           eo;
		int           top;
		int           lo;
		int           sh;
		logic         prod_neg;
		logic         neg;
		logic         guard;
		logic         sticky;
		logic         s_inf;
		logic         k_inf;
		logic         o_inf;

		prod_neg = s[31] ^ k[31];
		s_inf = s[30:0] == 31'h7F80_0000;
		k_inf = k[30:0] == 31'h7F80_0000;
		o_inf = o[30:0] == 31'h7F80_0000;

		// any NaN operand reads as the positive limit
		if (s[30:0] > 31'h7F80_0000 || k[30:0] > 31'h7F80_0000 ||
				o[30:0] > 31'h7F80_0000)
			return f2i8q_pkg::Q_MAX;
		if (s_inf || k_inf) begin
			// infinity times zero, or infinities of opposite sign: invalid
			if (s[30:0] == 31'd0 || k[30:0] == 31'd0)
				return f2i8q_pkg::Q_MAX;
			if (o_inf && o[31] != prod_neg)
				return f2i8q_pkg::Q_MAX;
			return prod_neg ? f2i8q_pkg::Q_MIN : f2i8q_pkg::Q_MAX;
		end
		if (o_inf)
			return o[31] ? f2i8q_pkg::Q_MIN : f2i8q_pkg::Q_MAX;

		// unpack, subnormals keep a zero hidden bit and the minimum exponent
		ms = {s[30:23] != 8'd0, s[22:0]};
		mk = {k[30:23] != 8'd0, k[22:0]};
		mo = {o[30:23] != 8'd0, o[22:0]};
		es = (s[30:23] == 8'd0) ? -149 : int'(s[30:23]) - 150;
		ek = (k[30:23] == 8'd0) ? -149 : int'(k[30:23]) - 150;
		eo = (o[30:23] == 8'd0) ? -149 : int'(o[30:23]) - 150;
		pm = ms * mk;
		prod = 576'(pm) << (es + ek + 298);
		bias = 576'(mo) << (eo + 298);

		if (prod_neg == o[31]) begin
			acc = prod + bias;
			neg = prod_neg;
		end else if (prod >= bias) begin
			acc = prod - bias;
			neg = prod_neg;
		end else begin
			acc = bias - prod;
			neg = o[31];
		end

		top = -1;
		for (int i = 575; i >= 0; i--) begin
			if (acc[i]) begin
				top = i;
				break;
			end
		end
		if (top < 0)
			return 8'sd0;
		if (top >= 306)
			return neg ? f2i8q_pkg::Q_MIN : f2i8q_pkg::Q_MAX;

		// round the exact sum once to fp32 precision, nearest even
		lo = (top - 23 < 149) ? 149 : top - 23;
		r = 64'(acc >> lo) & ((64'd1 << (top - lo + 1)) - 64'd1);
		guard = acc[lo - 1];
		sticky = |(acc & ((576'd1 << (lo - 1)) - 576'd1));
		if (guard && (sticky || r[0]))
			r = r + 64'd1;

		// fp32 to integer, ties away from zero
		sh = 298 - lo;
		mag = (sh > 40) ? 64'd0 : (r + (64'd1 << (sh - 1))) >> sh;
		if (neg)
			return (mag > 64'd128) ? f2i8q_pkg::Q_MIN : 8'(-int'(mag));
		return (mag > 64'd127) ? f2i8q_pkg::Q_MAX : 8'(mag);
	endfunction

	// Random fp32 operand: mostly values whose product lands near the int8
	// range, with some raw patterns and special encodings mixed in.
	function automatic logic [31:0] rand_fp(input int exp_lo, input int exp_hi);
		int pick;

		pick = $urandom_range(99);
		if (pick < 12)
			return $urandom();
		if (pick < 20) begin
			case ($urandom_range(7))
				0: return F_ZERO;
				1: return F_NZERO;
				2: return F_PINF;
				3: return F_NINF;
				4: return {1'($urandom_range(1)), 8'hFF,
					23'($urandom_range(1, 32'h7F_FFFF))};
				5: return {1'($urandom_range(1)), 8'h00, 23'($urandom())};
				6: return {1'($urandom_range(1)), 31'h7F7F_FFFF};
				default: return {1'($urandom_range(1)), 31'h0000_0001};
			endcase
		end
		if (pick < 30)	// short mantissa, makes exact ties likely
			return {1'($urandom_range(1)), 8'($urandom_range(exp_lo, exp_hi)),
				3'($urandom()), 20'd0};
		return {1'($urandom_range(1)), 8'($urandom_range(exp_lo, exp_hi)), 23'($urandom())};
	endfunction

	// Receiver: stall at the rate the current phase asks for.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Monitor: predict on every accepted request, check every accepted result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				pending_q.push_back(predict_quant(sample_bits, scale_bits, offset_bits));
			if (res_valid && !res_stall) begin
				n_checked++;
				if (pending_q.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("%0t: result %0d with nothing expected", $realtime, quantized);
				end else begin
					if (quantized !== pending_q[0]) begin
						n_mismatch++;
						if (n_mismatch <= 10)
							$display("%0t: quantized expected %0d, got %0d",
								$realtime, pending_q[0], quantized);
					end
					void'(pending_q.pop_front());
				end
			end
			// watchdog: count cycles in which neither channel moves
			if ((req_valid && !req_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout after %0d quiet cycles", IDLE_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Send one request: hold off as the phase asks, then hold the payload
	// until it is accepted.
	task automatic send_request(input logic [31:0] s, input logic [31:0] k,
			input logic [31:0] o);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid   <= 1'b1;
		sample_bits <= s;
		scale_bits  <= k;
		offset_bits <= o;
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
	endtask

	quant_row_t directed[] = '{
		'{F_ZERO,       F_ONE,        F_ZERO,  1'b0, 8'sd0},
		'{F_NZERO,      F_ONE,        F_NZERO, 1'b0, 8'sd0},
		'{F_HALF,       F_ONE,        F_ZERO,  1'b0, 8'sd1},
		'{F_NHALF,      F_ONE,        F_ZERO,  1'b0, -8'sd1},
		'{32'h4020_0000, F_ONE,       F_ZERO,  1'b0, 8'sd3},	// 2.5
		'{32'h3EFF_FFFF, F_ONE,       F_ZERO,  1'b0, 8'sd0},	// just under a half
		'{F_ONE,        F_ONE,        F_HALF,  1'b0, 8'sd2},	// 1.5
		'{32'h42FE_0000, F_ONE,       F_ZERO,  1'b0, 8'sd127},
		'{32'h42FF_0000, F_ONE,       F_ZERO,  1'b0, 8'sd127},	// 127.5 clamps
		'{32'hC300_0000, F_ONE,       F_ZERO,  1'b0, -8'sd128},
		'{32'hC301_0000, F_ONE,       F_ZERO,  1'b0, -8'sd128},
		'{F_PMAX,       F_PMAX,       F_ZERO,  1'b0, 8'sd127},
		'{F_NMAX,       F_PMAX,       F_ZERO,  1'b0, -8'sd128},
		'{F_MINSUB,     F_MINSUB,     F_MINSUB, 1'b0, 8'sd0},
		'{F_QNAN,       F_ONE,        F_ZERO,  1'b0, 8'sd127},
		'{F_ONE,        32'hFFFF_FFFF, F_ZERO, 1'b0, 8'sd127},
		'{F_ONE,        F_ONE,        32'hFF80_0001, 1'b0, 8'sd127},
		'{F_PINF,       F_ZERO,       F_ZERO,  1'b0, 8'sd127},
		'{F_NZERO,      F_NINF,       F_ZERO,  1'b0, 8'sd127},
		'{F_PINF,       F_ONE,        F_NINF,  1'b0, 8'sd127},
		'{F_PINF,       F_NINF,       F_PINF,  1'b0, 8'sd127},
		'{F_NINF,       F_ONE,        F_ZERO,  1'b0, -8'sd128},
		'{F_ONE,        F_ONE,        F_NINF,  1'b0, -8'sd128},
		'{F_ONE,        F_ONE,        F_PINF,  1'b0, 8'sd127},
		// single rounding of the fused sum decides these
		'{32'h3F80_0001, 32'h3F80_0001, 32'hBF80_0000, 1'b1, 8'sd0},
		'{32'h4B7F_FFFF, 32'h3F00_0000, 32'hCB00_0000, 1'b1, 8'sd0}
	};

	initial begin
		int n_directed;
		logic [31:0] s;
		logic [31:0] k;
		logic [31:0] o;

		arst_n          = 1'b0;
		req_valid       = 1'b0;
		sample_bits     = '0;
		scale_bits      = '0;
		offset_bits     = '0;
		n_mismatch      = 0;
		n_checked       = 0;
		idle_cycles     = 0;
		sender_idle_pct = 0;
		stall_pct       = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table; the fixed expectation overrides the prediction
		foreach (directed[i]) begin
			send_request(directed[i].sample, directed[i].scale, directed[i].offset);
			if (!directed[i].use_model)
				pending_q[pending_q.size() - 1] = directed[i].q;
		end
		n_directed = directed.size();

		// hold the sender until the pipe has drained completely
		req_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(negedge clk);

		// random part in four flow-control phases
		for (int n = 0; n < N_RANDOM; n++) begin
			case (n / (N_RANDOM / 4))
				0: begin sender_idle_pct = 0;  stall_pct = 0;  end
				1: begin sender_idle_pct = 70; stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  stall_pct = 70; end
				default: begin sender_idle_pct = 20; stall_pct = 20; end
			endcase
			s = rand_fp(110, 140);
			k = rand_fp(115, 135);
			o = ($urandom_range(3) == 0) ? F_ZERO : rand_fp(100, 134);
			send_request(s, k, o);
		end
		req_valid <= 1'b0;
		stall_pct = 0;

		while (pending_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		$display("Ran %0d directed and %0d random requests, %0d results checked",
			n_directed, N_RANDOM, n_checked);
		$display("Flow phases: free run, sender gaps, receiver stalls, both; %0d mismatches",
			n_mismatch);
		if (n_mismatch == 0 && pending_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/f2i8q_pkg.sv
src/f2i8q_wide_add.sv
src/fp32_to_int8_quantizer.sv
tb/tb.sv
